>>> src/delimited_frame_receiver_unit_macros.svh
// assertion macros for the delimited frame receiver checker
// no dependencies; taken in by the checker file
`ifndef DELIMITED_FRAME_RECEIVER_UNIT_MACROS_SVH
`define DELIMITED_FRAME_RECEIVER_UNIT_MACROS_SVH

// clocked assertion, masked while reset is applied
`define DFR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define DFR_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/dfr_pkg.sv
// shared types and constants for the delimited frame receiver
// no dependencies; used by every module of the block
`default_nettype none

package dfr_pkg;

	localparam int unsigned BUFFER_DEPTH_DEF = 64;
	localparam int unsigned BYTE_W           = 8;
	localparam int unsigned LEN_W            = 7;
	localparam int unsigned CFG_IDX_W        = 2;

	// input command codes
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_IDLE = 1'b1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEAD_ENABLE = 2'd0,
		REG_HEAD_BYTE   = 2'd1,
		REG_END_ENABLE  = 2'd2,
		REG_END_BYTE    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic              command;
		logic [BYTE_W-1:0] rx_byte;
	} rx_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] frame_byte;
		logic              last_byte;
		logic [LEN_W-1:0]  frame_length;
		logic              truncated;
	} frame_item_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic fetch;
		logic advance;
	} dfr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic emit;
		logic last;
	} dfr_status_t;

endpackage

`default_nettype wire

>>> src/delimited_frame_receiver_unit.sv
// Delimited frame receiver: assembles UART bytes into frames between optional
// head and end delimiter bytes and reads each completed frame out byte by byte.
// Depends on dfr_pkg, dfr_ctrl and dfr_datapath.
//
// in_valid/in_ready take one beat: a received byte or an idle-timeout event.
// While idle the block takes every input beat. A beat that completes a non-empty
// frame starts a read-out: the first byte is fetched from the frame store, then
// one output beat per cycle while out_ready is high, the last beat flagged by
// last_byte. frame_length and truncated hold on every beat. in_ready is low
// after the completing beat until the last output beat is taken, so no new
// input beat is taken during a read-out.
// A stalled receiver holds the current output beat unchanged.
// The cfg port writes one register per cycle when cfg_write is high; write only
// while the block is idle.
// Reset clears the frame state and configuration registers; no store clearing pass is needed.
`default_nettype none

module delimited_frame_receiver_unit import dfr_pkg::*; #(
	parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire rx_item_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output frame_item_t               out_data
);

	dfr_cmd_t    cmd;
	dfr_status_t st;

	// controller
	dfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// datapath
	dfr_datapath #(.DEPTH(BUFFER_DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.st        (st),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

>>> src/dfr_ctrl.sv
// controller state machine for the delimited frame receiver
// depends on dfr_pkg for the command and status structs
`default_nettype none

module dfr_ctrl import dfr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  wire logic  out_ready,
	input  wire dfr_status_t st,
	output dfr_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_FETCH = 3'b010,
		ST_SHOW  = 3'b100
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		cmd.take    = 1'b0;
		cmd.fetch   = 1'b0;
		cmd.advance = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				if (in_valid && st.emit) state_d = ST_FETCH;
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ST_SHOW;
			end
			ST_SHOW: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (st.last) state_d = ST_IDLE;
					else cmd.advance = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule

`default_nettype wire

>>> src/dfr_datapath.sv
// datapath: config registers, frame store, write position and read-out
// depends on dfr_pkg for payload, config and control types
`default_nettype none

module dfr_datapath import dfr_pkg::*; #(
	parameter  int unsigned DEPTH = BUFFER_DEPTH_DEF,
	localparam int unsigned AW    = $clog2(DEPTH),
	localparam int unsigned PW    = $clog2(DEPTH + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_data,
	input  wire rx_item_t             in_data,
	input  wire dfr_cmd_t             cmd,
	output dfr_status_t               st,
	output frame_item_t               out_data
);

	logic              head_en_q, end_en_q;
	logic [BYTE_W-1:0] head_byte_q, end_byte_q;
	logic [PW-1:0]     wp_q;
	logic              in_frame_q, ovf_q;
	logic [PW-1:0]     len_q;
	logic              trunc_q;
	logic [AW-1:0]     rd_idx_q;
	logic [BYTE_W-1:0] rd_data_q;
	logic [BYTE_W-1:0] mem [DEPTH];

	logic          cmd_idle, head_hit, counts, full, store, end_hit, emit;
	logic          mem_we;
	logic [AW-1:0] waddr, raddr;
	logic [PW-1:0] new_len;
	logic          new_ovf;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_en_q   <= 1'b0;
			head_byte_q <= '0;
			end_en_q    <= 1'b0;
			end_byte_q  <= '0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_HEAD_ENABLE: head_en_q   <= cfg_data[0];
				REG_HEAD_BYTE:   head_byte_q <= cfg_data;
				REG_END_ENABLE:  end_en_q    <= cfg_data[0];
				REG_END_BYTE:    end_byte_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// classify the incoming beat
	always_comb begin
		cmd_idle = (in_data.command == CMD_IDLE);
		head_hit = !cmd_idle && head_en_q && (in_data.rx_byte == head_byte_q);
		counts   = !head_en_q || in_frame_q;
		full     = (wp_q == PW'(DEPTH));
		store    = !cmd_idle && !head_hit && counts;
		end_hit  = store && end_en_q && (in_data.rx_byte == end_byte_q);
		emit     = (cmd_idle && !end_en_q && (wp_q != '0)) || end_hit;
		new_len  = (store && !full) ? wp_q + PW'(1) : wp_q;
		new_ovf  = ovf_q || (store && full);
		mem_we   = cmd.take && (head_hit || (store && !full));
		waddr    = head_hit ? '0 : wp_q[AW-1:0];
		raddr    = cmd.fetch ? '0 : rd_idx_q + AW'(1);
	end

	// frame assembly state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			in_frame_q <= 1'b0;
			ovf_q      <= 1'b0;
		end else if (cmd.take) begin
			if (cmd_idle || end_hit) begin
				wp_q       <= '0;
				in_frame_q <= 1'b0;
				ovf_q      <= 1'b0;
			end else if (head_hit) begin
				wp_q       <= PW'(1);
				in_frame_q <= 1'b1;
				ovf_q      <= 1'b0;
			end else if (store) begin
				if (full) ovf_q <= 1'b1;
				else wp_q <= wp_q + PW'(1);
			end
		end
	end

	// snapshot of the completed frame
	always_ff @(posedge clk) begin
		if (cmd.take && emit) begin
			len_q   <= new_len;
			trunc_q <= new_ovf;
		end
	end

	// frame store, write and registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= in_data.rx_byte;
		if (cmd.fetch || cmd.advance) rd_data_q <= mem[raddr];
	end

	// read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_idx_q <= '0;
		else if (cmd.fetch || cmd.advance) rd_idx_q <= raddr;
	end

	// status and output beat
	always_comb begin
		st.emit               = emit;
		st.last               = (PW'(rd_idx_q) + PW'(1)) == len_q;
		out_data.frame_byte   = rd_data_q;
		out_data.last_byte    = st.last;
		out_data.frame_length = LEN_W'(len_q);
		out_data.truncated    = trunc_q;
	end

endmodule

`default_nettype wire

>>> src/dfr_checker.sv
// port-level assertions for the delimited frame receiver, with its bind
// depends on dfr_pkg and delimited_frame_receiver_unit_macros.svh
`default_nettype none
`include "delimited_frame_receiver_unit_macros.svh"

module dfr_checker import dfr_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	input wire logic  in_ready,
	input wire logic  out_valid,
	input wire logic  out_ready,
	input wire frame_item_t out_data
);

	// no output beat during reset
	`DFR_ASSERT_RST(a_reset_quiet, !arst_n |-> !out_valid, "output valid during reset")

	// input is closed while a frame is being read out
	`DFR_ASSERT(a_no_overlap, !(in_ready && out_valid), "input open during read-out")

	// a stalled output beat holds
	`DFR_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "output beat changed while stalled")

	// read-out ends after the last beat
	`DFR_ASSERT(a_last_ends, (out_valid && out_ready && out_data.last_byte) |=> !out_valid, "output continues past last beat")

	// frame length and flag stay fixed through a frame
	`DFR_ASSERT(a_len_steady, (out_valid && out_ready && !out_data.last_byte) |=> (out_valid && $stable(out_data.frame_length) && $stable(out_data.truncated)), "frame attributes changed mid-frame")

endmodule

bind delimited_frame_receiver_unit dfr_checker u_dfr_checker (.*);

`default_nettype wire
